>>> sv/pfqd_pkg.sv
// shared constants, types and state encodings of the prime factor quotient distance block
package pfqd_pkg;

	localparam int TABLE_SIZE = 131072;
	localparam int ADDR_W     = $clog2(TABLE_SIZE);
	localparam int VAL_W      = 17;
	localparam int DIST_W     = 18;
	localparam int ROOT_W     = (ADDR_W + 1) / 2 + 1;
	localparam int CNT_W      = $clog2(VAL_W + 1);
	localparam int SHIFT_W    = $clog2(VAL_W + 1);

	localparam int EVEN_PRIME       = 2;
	localparam int FIRST_EVEN_COMP  = 4;
	localparam int FIRST_ODD_PRIME  = 3;

	typedef struct packed {
		logic             bad;
		logic [VAL_W-1:0] x;
		logic [VAL_W-1:0] y;
	} item_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} lookup_req_t;

	typedef enum logic [2:0] {
		SV_INIT,
		SV_ICHK,
		SV_IWAIT,
		SV_MARK,
		SV_NEXT,
		SV_DONE
	} sieve_state_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_GCD,
		BK_LOOK,
		BK_WAIT,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

>>> sv/pfqd_front.sv
// front part: accepts items, flags bad operands and queues them for the back part
module pfqd_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       table_ready,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [pfqd_pkg::VAL_W-1:0] first_value,
	input  logic [pfqd_pkg::VAL_W-1:0] second_value,
	output logic                       q_valid,
	output pfqd_pkg::item_t            q_item,
	input  logic                       q_pop
);

	pfqd_pkg::item_t ent_q [2];
	logic            wptr_q;
	logic            rptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;
	logic            oor;
	pfqd_pkg::item_t new_item;

	assign in_stall = !table_ready || (count_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = ent_q[rptr_q];
	assign pop      = q_pop && q_valid;

	// operands at or beyond the table size cannot be looked up
	assign oor = ({1'b0, first_value} >= (pfqd_pkg::VAL_W+1)'(pfqd_pkg::TABLE_SIZE)) ||
		({1'b0, second_value} >= (pfqd_pkg::VAL_W+1)'(pfqd_pkg::TABLE_SIZE));

	always_comb begin
		new_item.x   = first_value;
		new_item.y   = second_value;
		new_item.bad = (first_value == '0) || (second_value == '0) || oor;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

>>> sv/pfqd_spf_table.sv
// smallest prime factor memory with its sieve fill after reset
module pfqd_spf_table (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfqd_pkg::lookup_req_t       req,
	output logic [pfqd_pkg::VAL_W-1:0]  rdata,
	output logic                        ready
);

	// an entry of zero means the index itself is prime (or below two)
	logic [pfqd_pkg::VAL_W-1:0]    mem [pfqd_pkg::TABLE_SIZE];
	logic [pfqd_pkg::VAL_W-1:0]    rdata_q;

	pfqd_pkg::sieve_state_t        state_q, state_d;
	logic [pfqd_pkg::ADDR_W-1:0]   c_q;
	logic [pfqd_pkg::ROOT_W-1:0]   i_q;
	logic [pfqd_pkg::ADDR_W:0]     j_q;
	logic [pfqd_pkg::ADDR_W-1:0]   wj_q;
	logic                          pend_q;

	logic                          we;
	logic [pfqd_pkg::ADDR_W-1:0]   waddr;
	logic [pfqd_pkg::VAL_W-1:0]    wdata;
	logic                          re;
	logic [pfqd_pkg::ADDR_W-1:0]   raddr;
	logic [pfqd_pkg::ROOT_W-1:0]   i_nxt;
	logic [2*pfqd_pkg::ROOT_W-1:0] i_sq;
	logic [2*pfqd_pkg::ROOT_W-1:0] j_first;
	logic                          j_in;

	assign i_nxt   = i_q + 1'b1;
	assign i_sq    = i_nxt * i_nxt;
	assign j_first = i_q * i_q;
	assign j_in    = (j_q < (pfqd_pkg::ADDR_W+1)'(pfqd_pkg::TABLE_SIZE));
	assign rdata   = rdata_q;
	assign ready   = (state_q == pfqd_pkg::SV_DONE);

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = c_q;
		wdata   = '0;
		re      = 1'b0;
		raddr   = req.addr;
		unique case (state_q)
			pfqd_pkg::SV_INIT: begin
				we    = 1'b1;
				waddr = c_q;
				if (!c_q[0] && (c_q >= pfqd_pkg::ADDR_W'(pfqd_pkg::FIRST_EVEN_COMP))) begin
					wdata = pfqd_pkg::VAL_W'(pfqd_pkg::EVEN_PRIME);
				end
				if (c_q == pfqd_pkg::ADDR_W'(pfqd_pkg::TABLE_SIZE - 1)) begin
					state_d = pfqd_pkg::SV_ICHK;
				end
			end
			pfqd_pkg::SV_ICHK: begin
				re      = 1'b1;
				raddr   = pfqd_pkg::ADDR_W'(i_q);
				state_d = pfqd_pkg::SV_IWAIT;
			end
			pfqd_pkg::SV_IWAIT: begin
				state_d = (rdata_q == '0) ? pfqd_pkg::SV_MARK : pfqd_pkg::SV_NEXT;
			end
			pfqd_pkg::SV_MARK: begin
				if (pend_q && (rdata_q == '0)) begin
					we    = 1'b1;
					waddr = wj_q;
					wdata = pfqd_pkg::VAL_W'(i_q);
				end
				if (j_in) begin
					re    = 1'b1;
					raddr = j_q[pfqd_pkg::ADDR_W-1:0];
				end else begin
					state_d = pfqd_pkg::SV_NEXT;
				end
			end
			pfqd_pkg::SV_NEXT: begin
				if (i_sq >= (2*pfqd_pkg::ROOT_W)'(pfqd_pkg::TABLE_SIZE)) begin
					state_d = pfqd_pkg::SV_DONE;
				end else begin
					state_d = pfqd_pkg::SV_ICHK;
				end
			end
			pfqd_pkg::SV_DONE: begin
				re    = req.en;
				raddr = req.addr;
			end
			default: state_d = pfqd_pkg::SV_INIT;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfqd_pkg::SV_INIT;
			c_q     <= '0;
			i_q     <= pfqd_pkg::ROOT_W'(pfqd_pkg::FIRST_ODD_PRIME);
			j_q     <= '0;
			wj_q    <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				pfqd_pkg::SV_INIT: c_q <= c_q + 1'b1;
				pfqd_pkg::SV_IWAIT: begin
					j_q    <= (pfqd_pkg::ADDR_W+1)'(j_first);
					pend_q <= 1'b0;
				end
				pfqd_pkg::SV_MARK: begin
					pend_q <= j_in;
					wj_q   <= j_q[pfqd_pkg::ADDR_W-1:0];
					j_q    <= j_q + (pfqd_pkg::ADDR_W+1)'(i_q);
				end
				pfqd_pkg::SV_NEXT: i_q <= i_nxt;
				default: ;
			endcase
		end
	end

endmodule

>>> sv/pfqd_back.sv
// back part: binary gcd, table driven factoring of both operands and the gcd, result register
module pfqd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  pfqd_pkg::item_t             q_item,
	output logic                        q_pop,
	output pfqd_pkg::lookup_req_t       req,
	input  logic [pfqd_pkg::VAL_W-1:0]  rdata,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pfqd_pkg::DIST_W-1:0] distance,
	output logic                        bad_operand
);

	pfqd_pkg::back_state_t        state_q, state_d;
	logic [pfqd_pkg::VAL_W-1:0]   x_q, y_q, g_q, a_q, b_q, v_q, p_q, quo_q;
	logic [pfqd_pkg::VAL_W:0]     rem_q;
	logic [pfqd_pkg::SHIFT_W-1:0] k_q;
	logic [pfqd_pkg::CNT_W-1:0]   cnt_q;
	logic [1:0]                   sel_q;
	logic [pfqd_pkg::DIST_W-1:0]  acc_q;
	logic                         bad_q;
	logic                         out_valid_q;
	logic [pfqd_pkg::DIST_W-1:0]  dist_q;
	logic                         bad_out_q;

	logic [pfqd_pkg::VAL_W:0]     trial;
	logic                         fits;
	logic [pfqd_pkg::DIST_W-1:0]  add_src;
	logic [pfqd_pkg::DIST_W-1:0]  acc_upd;
	logic                         load_out;

	assign out_valid   = out_valid_q;
	assign distance    = dist_q;
	assign bad_operand = bad_out_q;

	// one restoring division step per cycle
	assign trial = {rem_q[pfqd_pkg::VAL_W-1:0], quo_q[pfqd_pkg::VAL_W-1]};
	assign fits  = (trial >= {1'b0, p_q});

	// gcd factors are taken off twice, once for each operand
	assign add_src = (rdata == '0) ? pfqd_pkg::DIST_W'(v_q) : pfqd_pkg::DIST_W'(rdata);
	assign acc_upd = (sel_q == 2'd2) ? acc_q - (add_src << 1) : acc_q + add_src;

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		req.en   = 1'b0;
		req.addr = v_q[pfqd_pkg::ADDR_W-1:0];
		load_out = 1'b0;
		unique case (state_q)
			pfqd_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					state_d = q_item.bad ? pfqd_pkg::BK_FIN : pfqd_pkg::BK_GCD;
				end
			end
			pfqd_pkg::BK_GCD: begin
				if ((a_q == '0) || (b_q == '0)) begin
					state_d = pfqd_pkg::BK_LOOK;
				end
			end
			pfqd_pkg::BK_LOOK: begin
				if (v_q > pfqd_pkg::VAL_W'(1)) begin
					req.en  = 1'b1;
					state_d = pfqd_pkg::BK_WAIT;
				end else if (sel_q == 2'd2) begin
					state_d = pfqd_pkg::BK_FIN;
				end
			end
			pfqd_pkg::BK_WAIT: begin
				if ((rdata == '0) || (rdata == pfqd_pkg::VAL_W'(pfqd_pkg::EVEN_PRIME))) begin
					state_d = pfqd_pkg::BK_LOOK;
				end else begin
					state_d = pfqd_pkg::BK_DIV;
				end
			end
			pfqd_pkg::BK_DIV: begin
				if (cnt_q == pfqd_pkg::CNT_W'(1)) begin
					state_d = pfqd_pkg::BK_LOOK;
				end
			end
			pfqd_pkg::BK_FIN: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = pfqd_pkg::BK_IDLE;
				end
			end
			default: state_d = pfqd_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pfqd_pkg::BK_IDLE: begin
				x_q   <= q_item.x;
				y_q   <= q_item.y;
				a_q   <= q_item.x;
				b_q   <= q_item.y;
				k_q   <= '0;
				acc_q <= '0;
				bad_q <= q_item.bad;
				sel_q <= 2'd0;
			end
			pfqd_pkg::BK_GCD: begin
				if ((a_q == '0) || (b_q == '0)) begin
					g_q <= (a_q | b_q) << k_q;
					v_q <= x_q;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= a_q - b_q;
				end else begin
					b_q <= b_q - a_q;
				end
			end
			pfqd_pkg::BK_LOOK: begin
				if (v_q <= pfqd_pkg::VAL_W'(1)) begin
					if (sel_q == 2'd0) begin
						v_q   <= y_q;
						sel_q <= 2'd1;
					end else if (sel_q == 2'd1) begin
						v_q   <= g_q;
						sel_q <= 2'd2;
					end
				end
			end
			pfqd_pkg::BK_WAIT: begin
				acc_q <= acc_upd;
				p_q   <= rdata;
				rem_q <= '0;
				quo_q <= v_q;
				cnt_q <= pfqd_pkg::CNT_W'(pfqd_pkg::VAL_W);
				if (rdata == '0) begin
					v_q <= pfqd_pkg::VAL_W'(1);
				end else if (rdata == pfqd_pkg::VAL_W'(pfqd_pkg::EVEN_PRIME)) begin
					v_q <= v_q >> 1;
				end
			end
			pfqd_pkg::BK_DIV: begin
				rem_q <= fits ? trial - {1'b0, p_q} : trial;
				quo_q <= {quo_q[pfqd_pkg::VAL_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == pfqd_pkg::CNT_W'(1)) begin
					v_q <= {quo_q[pfqd_pkg::VAL_W-2:0], fits};
				end
			end
			default: ;
		endcase
		if (load_out) begin
			dist_q    <= bad_q ? '0 : acc_q;
			bad_out_q <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfqd_pkg::BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> sv/prime_factor_quotient_distance_core.sv
// top level of the prime factor quotient distance block
//
// input channel: in_valid / in_stall carry one item of two operands
// (first_value, second_value); an item is taken at a clock edge with valid
// high and stall low. output channel: out_valid / out_stall carry distance
// and bad_operand, the sum of prime factors of both operands after both are
// divided by their gcd. a zero operand gives bad_operand and distance 0.
// after arst_n the smallest prime factor memory is filled by a sieve: one
// pass writing every entry, then the odd prime marking pass. in_stall stays
// high until that is done.
// per item: the item goes into the queue, then through the binary gcd, then
// for each prime factor of each operand and of the gcd a memory lookup plus
// a bit-serial division (factor 2 and the last prime skip the division),
// then the result register is loaded. the back end works on one item at a
// time, so it takes a new item only once the last one is in the result
// register; its single memory read port and the divider set the rate. a two
// entry queue lets items arrive while the back end works, and the back end
// starts the next item while a result waits under out_stall.
module prime_factor_quotient_distance_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [pfqd_pkg::VAL_W-1:0]  first_value,
	input  logic [pfqd_pkg::VAL_W-1:0]  second_value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [pfqd_pkg::DIST_W-1:0] distance,
	output logic                        bad_operand
);

	logic                        table_ready;
	logic                        q_valid;
	logic                        q_pop;
	pfqd_pkg::item_t             q_item;
	pfqd_pkg::lookup_req_t       req;
	logic [pfqd_pkg::VAL_W-1:0]  rdata;

	// accept, flag bad operands, queue
	pfqd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.table_ready  (table_ready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.first_value  (first_value),
		.second_value (second_value),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop)
	);

	// sieve filled lookup memory
	pfqd_spf_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata),
		.ready  (table_ready)
	);

	// gcd, factoring and result register
	pfqd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.req         (req),
		.rdata       (rdata),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.distance    (distance),
		.bad_operand (bad_operand)
	);

endmodule
